// ===== hw/rtl/apf_pkg.sv =====
package apf_pkg;

   localparam int NODE_W    = 5;   // node id width
   localparam int CNT_W     = 6;   // node count, visit number and low link width
   localparam int TALLY_W   = 2;
   localparam int NODES_DEF = 32;
   localparam int EDGES_DEF = 128;
   localparam int MAX_OUT   = 32;  // result items per run, end item included

   localparam logic [CNT_W-1:0]   NODE_COUNT_RST = CNT_W'(32);
   localparam logic [CNT_W-1:0]   VISIT_ROOT     = CNT_W'(1);
   localparam logic [TALLY_W-1:0] TALLY_MAX      = TALLY_W'(2);

   // commands from the controller, one per cycle at most
   typedef struct packed {
      logic capture;
      logic rd_a;
      logic wr_a;
      logic wr_b;
      logic rd_root;
      logic root;
      logic edge_step;
      logic nbr;
      logic pop;
      logic restore;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic edge_ok;
      logic last;
      logic live;
      logic below;
      logic pop_emit;
      logic out_busy;
   } status_type;

endpackage

// ===== hw/rtl/apf_req_if.sv =====
interface apf_req_if import apf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] end_a;
   logic [NODE_W-1:0] end_b;
   logic              last_edge;

   modport source (output valid, end_a, end_b, last_edge, input ready);
   modport sink   (input valid, end_a, end_b, last_edge, output ready);
endinterface

// ===== hw/rtl/apf_rsp_if.sv =====
interface apf_rsp_if import apf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] point_node;
   logic              end_of_run;
   logic              overflow;

   modport source (output valid, point_node, end_of_run, overflow, input ready);
   modport sink   (input valid, point_node, end_of_run, overflow, output ready);
endinterface

// ===== hw/rtl/articulation_point_finder_top.sv =====
// articulation point finder: takes an undirected graph as a stream of edge items
// (end_a, end_b, last_edge), appends each edge to both endpoints' neighbour lists
// in arrival order, and after the item flagged last_edge runs a depth-first walk
// from node 0, emitting one item per articulation point in post-order and then an
// end item whose overflow bit tells whether any edge was dropped (bad node id or
// full list store). a stored edge is loaded in steps set by the single write port of
// the list stores (accept, read tails, append end_a, append end_b); a dropped edge
// is only accepted and checked. the walk takes, per stored list entry, a fetch, a read
// and a neighbour step, per node visited an empty fetch, a pop and a restore or end,
// plus a start and a root step, and it waits while the result side stalls. together
// with the end item all graph state is cleared; node_count (csr_wdata, reset 32) is
// kept and should only be written while the
// block is idle
module articulation_point_finder_top import apf_pkg::*; #(
   parameter int NODES = NODES_DEF,   // node store depth, stack depth
   parameter int EDGES = EDGES_DEF    // edge capacity, two list entries each
) (
   input  logic             clock,
   input  logic             reset,
   apf_req_if.sink          req_chan,
   apf_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);
   cmd_type    cmd;
   status_type status;

   // sequencer: loading, walk steps, result pacing
   apf_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // list stores, walk stack, per-node visit numbers and the output register
   apf_datapath #(.NODES(NODES), .EDGES(EDGES)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_end_a      (req_chan.end_a),
      .req_end_b      (req_chan.end_b),
      .req_last_edge  (req_chan.last_edge),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_point_node (rsp_chan.point_node),
      .rsp_end_of_run (rsp_chan.end_of_run),
      .rsp_overflow   (rsp_chan.overflow)
   );
endmodule

// ===== hw/rtl/apf_ram.sv =====
module apf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/apf_control.sv =====
module apf_control import apf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LOAD_A  = 4'd1;
   localparam logic [3:0] S_WR_A    = 4'd2;
   localparam logic [3:0] S_WR_B    = 4'd3;
   localparam logic [3:0] S_START   = 4'd4;
   localparam logic [3:0] S_ROOT    = 4'd5;
   localparam logic [3:0] S_FETCH   = 4'd6;
   localparam logic [3:0] S_EDGE    = 4'd7;
   localparam logic [3:0] S_NBR     = 4'd8;
   localparam logic [3:0] S_POP     = 4'd9;
   localparam logic [3:0] S_RESTORE = 4'd10;
   localparam logic [3:0] S_END     = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_LOAD_A;
            end
         end
         S_LOAD_A: begin
            cmd.rd_a = 1'b1;
            if (status.edge_ok) begin
               state_in = S_WR_A;
            end else begin
               state_in = status.last ? S_START : S_IDLE;
            end
         end
         S_WR_A: begin
            cmd.wr_a = 1'b1;
            state_in = S_WR_B;
         end
         S_WR_B: begin
            cmd.wr_b = 1'b1;
            state_in = status.last ? S_START : S_IDLE;
         end
         S_START: begin
            cmd.rd_root = 1'b1;
            state_in    = S_ROOT;
         end
         S_ROOT: begin
            cmd.root = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (status.live) begin
               state_in = S_EDGE;
            end else begin
               state_in = S_POP;
            end
         end
         S_EDGE: begin
            cmd.edge_step = 1'b1;
            state_in      = S_NBR;
         end
         S_NBR: begin
            cmd.nbr  = 1'b1;
            state_in = S_FETCH;
         end
         S_POP: begin
            if (!(status.pop_emit && status.out_busy)) begin
               cmd.pop  = 1'b1;
               state_in = status.below ? S_RESTORE : S_END;
            end
         end
         S_RESTORE: begin
            cmd.restore = 1'b1;
            state_in    = S_FETCH;
         end
         S_END: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hw/rtl/apf_datapath.sv =====
module apf_datapath import apf_pkg::*; #(
   parameter int NODES = NODES_DEF,
   parameter int EDGES = EDGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [NODE_W-1:0] req_end_a,
   input  logic [NODE_W-1:0] req_end_b,
   input  logic              req_last_edge,
   input  logic              csr_we,
   input  logic [CNT_W-1:0]  csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [NODE_W-1:0] rsp_point_node,
   output logic              rsp_end_of_run,
   output logic              rsp_overflow
);
   localparam int SLOTS = 2 * EDGES;
   localparam int IW    = $clog2(SLOTS);
   localparam int UW    = $clog2(SLOTS + 1);
   localparam int NAW   = $clog2(NODES);
   localparam int DW    = $clog2(NODES + 1);
   localparam int FW    = 2 * NODE_W + 2 * IW + 1 + 2 * CNT_W + 1 + TALLY_W;
   localparam logic [CNT_W-1:0] NODES_CAP = CNT_W'(NODES);

   // control state
   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic [UW-1:0]    used_ff, used_in;
   logic             dropped_ff, dropped_in;
   logic [NODES-1:0] has_ff, has_in;
   logic [NODES-1:0] visited_ff, visited_in;
   logic [CNT_W-1:0] vclk_ff, vclk_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [NODE_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic               last_ff, last_in, ok_ff, ok_in;
   logic [IW-1:0]      prev_e_ff, prev_e_in;
   logic [NODE_W-1:0]  v_ff, v_in;
   logic [CNT_W-1:0]   child_low_ff, child_low_in;
   logic [NODE_W-1:0]  f_node_ff, f_node_in, f_parent_ff, f_parent_in;
   logic [IW-1:0]      f_cursor_ff, f_cursor_in, f_tail_ff, f_tail_in;
   logic               f_live_ff, f_live_in, f_cut_ff, f_cut_in;
   logic [CNT_W-1:0]   f_vnum_ff, f_vnum_in, f_low_ff, f_low_in;
   logic [TALLY_W-1:0] f_tally_ff, f_tally_in;
   logic [NODE_W-1:0]  point_ff, point_in;
   logic               eor_ff, eor_in, ovf_ff, ovf_in;

   // memory ports
   logic              head_we, tail_we, next_we, dest_we, vnum_we, stk_we;
   logic [NAW-1:0]    head_wa, tail_wa, nt_ra, vnum_wa, vnum_ra, stk_wa, stk_ra;
   logic [IW-1:0]     head_wd, tail_wd, head_rd, tail_rd;
   logic [IW-1:0]     next_wa, next_wd, next_rd, dest_wa, ent_ra;
   logic [NODE_W-1:0] dest_wd, dest_rd;
   logic [CNT_W-1:0]  vnum_wd, vnum_rd;
   logic [FW-1:0]     stk_wd, stk_rd;

   logic [NODE_W-1:0]  s_node, s_parent;
   logic [IW-1:0]      s_cursor, s_tail;
   logic               s_live, s_cut;
   logic [CNT_W-1:0]   s_vnum, s_low;
   logic [TALLY_W-1:0] s_tally;

   logic [CNT_W-1:0] lim;
   logic [UW:0]      used_plus2;
   logic [NAW-1:0]   na, nb, nv;
   logic [IW-1:0]    eidx, tail_b;
   logic [DW-1:0]    dm1, dm2;
   logic             emit, v_in_range, out_busy;

   assign {s_node, s_parent, s_cursor, s_tail, s_live, s_vnum, s_low, s_cut, s_tally} = stk_rd;

   assign lim        = (node_count_ff < NODES_CAP) ? node_count_ff : NODES_CAP;
   assign used_plus2 = {1'b0, used_ff} + (UW + 1)'(2);
   assign na         = NAW'(a_ff);
   assign nb         = NAW'(b_ff);
   assign nv         = NAW'(v_ff);
   assign eidx       = used_ff[IW-1:0];
   // self loop: the read of b's tail saw the value before a's append
   assign tail_b     = (a_ff == b_ff) ? prev_e_ff : tail_rd;
   assign dm1        = depth_ff - DW'(1);
   assign dm2        = depth_ff - DW'(2);
   assign v_in_range = (32'(v_ff) < NODES);
   assign emit       = f_cut_ff || (f_vnum_ff == VISIT_ROOT && f_tally_ff > TALLY_W'(1));
   assign out_busy   = rsp_valid_ff && !rsp_ready;

   assign status.edge_ok  = ok_ff;
   assign status.last     = last_ff;
   assign status.live     = f_live_ff;
   assign status.below    = (depth_ff > DW'(1));
   assign status.pop_emit = emit;
   assign status.out_busy = out_busy;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_node = point_ff;
   assign rsp_end_of_run = eor_ff;
   assign rsp_overflow   = ovf_ff;

   // read addresses
   always_comb begin
      nt_ra = NAW'(dest_rd);
      if (cmd.rd_a) begin
         nt_ra = na;
      end else if (cmd.wr_a) begin
         nt_ra = nb;
      end else if (cmd.rd_root) begin
         nt_ra = '0;
      end
   end
   assign vnum_ra = NAW'(dest_rd);
   assign ent_ra  = f_cursor_ff;
   assign stk_ra  = dm2[NAW-1:0];

   always_comb begin
      node_count_in = csr_we ? csr_wdata : node_count_ff;
      used_in       = used_ff;
      dropped_in    = dropped_ff;
      has_in        = has_ff;
      visited_in    = visited_ff;
      vclk_in       = vclk_ff;
      depth_in      = depth_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      a_in          = a_ff;
      b_in          = b_ff;
      last_in       = last_ff;
      ok_in         = ok_ff;
      prev_e_in     = prev_e_ff;
      v_in          = v_ff;
      child_low_in  = child_low_ff;
      f_node_in     = f_node_ff;
      f_parent_in   = f_parent_ff;
      f_cursor_in   = f_cursor_ff;
      f_tail_in     = f_tail_ff;
      f_live_in     = f_live_ff;
      f_vnum_in     = f_vnum_ff;
      f_low_in      = f_low_ff;
      f_cut_in      = f_cut_ff;
      f_tally_in    = f_tally_ff;
      point_in      = point_ff;
      eor_in        = eor_ff;
      ovf_in        = ovf_ff;
      head_we = 1'b0; head_wa = na;  head_wd = eidx;
      tail_we = 1'b0; tail_wa = na;  tail_wd = eidx;
      next_we = 1'b0; next_wa = tail_rd; next_wd = eidx;
      dest_we = 1'b0; dest_wa = eidx; dest_wd = b_ff;
      vnum_we = 1'b0; vnum_wa = nv;  vnum_wd = vclk_ff + CNT_W'(1);
      stk_we  = 1'b0; stk_wa  = dm1[NAW-1:0];
      stk_wd  = {f_node_ff, f_parent_ff, f_cursor_ff, f_tail_ff, f_live_ff,
                 f_vnum_ff, f_low_ff, f_cut_ff, f_tally_ff};

      if (cmd.capture) begin
         a_in    = req_end_a;
         b_in    = req_end_b;
         last_in = req_last_edge;
         ok_in   = ({1'b0, req_end_a} < lim) && ({1'b0, req_end_b} < lim)
                   && (used_plus2 <= (UW + 1)'(SLOTS));
      end
      if (cmd.rd_a && !ok_ff) begin
         dropped_in = 1'b1;
      end
      if (cmd.wr_a) begin
         dest_we   = 1'b1;
         next_we   = has_ff[na];
         head_we   = !has_ff[na];
         tail_we   = 1'b1;
         has_in[na] = 1'b1;
         used_in   = used_ff + UW'(1);
         prev_e_in = eidx;
      end
      if (cmd.wr_b) begin
         dest_we   = 1'b1;
         dest_wd   = a_ff;
         next_wa   = tail_b;
         next_we   = has_ff[nb];
         head_we   = !has_ff[nb];
         head_wa   = nb;
         tail_we   = 1'b1;
         tail_wa   = nb;
         has_in[nb] = 1'b1;
         used_in   = used_ff + UW'(1);
      end
      if (cmd.root) begin
         f_node_in     = '0;
         f_parent_in   = '0;
         f_cursor_in   = head_rd;
         f_tail_in     = tail_rd;
         f_live_in     = has_ff[0];
         f_vnum_in     = VISIT_ROOT;
         f_low_in      = VISIT_ROOT;
         f_cut_in      = 1'b0;
         f_tally_in    = '0;
         visited_in[0] = 1'b1;
         vnum_we       = 1'b1;
         vnum_wa       = '0;
         vnum_wd       = VISIT_ROOT;
         vclk_in       = VISIT_ROOT;
         depth_in      = DW'(1);
      end
      if (cmd.edge_step) begin
         f_cursor_in = next_rd;
         f_live_in   = (f_cursor_ff != f_tail_ff);
         v_in        = dest_rd;
      end
      if (cmd.nbr && v_in_range) begin
         if (!visited_ff[nv]) begin
            // descend: spill the current frame, open one for the neighbour
            stk_we         = 1'b1;
            vnum_we        = 1'b1;
            visited_in[nv] = 1'b1;
            vclk_in        = vclk_ff + CNT_W'(1);
            depth_in       = depth_ff + DW'(1);
            f_node_in      = v_ff;
            f_parent_in    = f_node_ff;
            f_cursor_in    = head_rd;
            f_tail_in      = tail_rd;
            f_live_in      = has_ff[nv];
            f_vnum_in      = vclk_ff + CNT_W'(1);
            f_low_in       = vclk_ff + CNT_W'(1);
            f_cut_in       = 1'b0;
            f_tally_in     = '0;
         end else if (v_ff != f_parent_ff && vnum_rd < f_low_ff) begin
            f_low_in = vnum_rd;
         end
      end
      if (cmd.pop) begin
         depth_in     = dm1;
         child_low_in = f_low_ff;
         if (emit && cnt_ff < CNT_W'(MAX_OUT - 1)) begin
            rsp_valid_in = 1'b1;
            point_in     = f_node_ff;
            eor_in       = 1'b0;
            ovf_in       = 1'b0;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.restore) begin
         f_node_in   = s_node;
         f_parent_in = s_parent;
         f_cursor_in = s_cursor;
         f_tail_in   = s_tail;
         f_live_in   = s_live;
         f_vnum_in   = s_vnum;
         f_low_in    = (child_low_ff < s_low) ? child_low_ff : s_low;
         f_cut_in    = s_cut || (s_vnum > VISIT_ROOT && child_low_ff >= s_vnum);
         f_tally_in  = (s_tally < TALLY_MAX) ? s_tally + TALLY_W'(1) : s_tally;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         point_in     = '0;
         eor_in       = 1'b1;
         ovf_in       = dropped_ff;
         used_in      = '0;
         dropped_in   = 1'b0;
         has_in       = '0;
         visited_in   = '0;
         vclk_in      = '0;
         depth_in     = '0;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         used_ff       <= '0;
         dropped_ff    <= 1'b0;
         has_ff        <= '0;
         visited_ff    <= '0;
         vclk_ff       <= '0;
         depth_ff      <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         used_ff       <= used_in;
         dropped_ff    <= dropped_in;
         has_ff        <= has_in;
         visited_ff    <= visited_in;
         vclk_ff       <= vclk_in;
         depth_ff      <= depth_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      last_ff      <= last_in;
      ok_ff        <= ok_in;
      prev_e_ff    <= prev_e_in;
      v_ff         <= v_in;
      child_low_ff <= child_low_in;
      f_node_ff    <= f_node_in;
      f_parent_ff  <= f_parent_in;
      f_cursor_ff  <= f_cursor_in;
      f_tail_ff    <= f_tail_in;
      f_live_ff    <= f_live_in;
      f_vnum_ff    <= f_vnum_in;
      f_low_ff     <= f_low_in;
      f_cut_ff     <= f_cut_in;
      f_tally_ff   <= f_tally_in;
      point_ff     <= point_in;
      eor_ff       <= eor_in;
      ovf_ff       <= ovf_in;
   end

   apf_ram #(.WIDTH(IW), .DEPTH(NODES)) u_head (
      .clock(clock), .we(head_we), .waddr(head_wa), .wdata(head_wd),
      .raddr(nt_ra), .rdata(head_rd));
   apf_ram #(.WIDTH(IW), .DEPTH(NODES)) u_tail (
      .clock(clock), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
      .raddr(nt_ra), .rdata(tail_rd));
   apf_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(ent_ra), .rdata(next_rd));
   apf_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_dest (
      .clock(clock), .we(dest_we), .waddr(dest_wa), .wdata(dest_wd),
      .raddr(ent_ra), .rdata(dest_rd));
   apf_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_vnum (
      .clock(clock), .we(vnum_we), .waddr(vnum_wa), .wdata(vnum_wd),
      .raddr(vnum_ra), .rdata(vnum_rd));
   apf_ram #(.WIDTH(FW), .DEPTH(NODES)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_rd));
endmodule

// ===== tb/articulation_point_finder_top_test.sv =====
module articulation_point_finder_top_test;
   import apf_pkg::*;

   typedef struct {
      logic [NODE_W-1:0] node;
      logic              done;
      logic              ovf;
   } point_item_type;

   // scoreboard: keeps its own copy of the graph and runs the cut-vertex search
   // when the closing edge goes in
   class cut_vertex_board;
      int unsigned       nbr_list[NODES_DEF][$];
      int unsigned       entries;
      bit                dropped;
      int unsigned       node_count;
      point_item_type    due_points[$];

      function new();
         node_count = 32;
         wipe();
      endfunction

      function void wipe();
         foreach (nbr_list[i]) nbr_list[i].delete();
         entries = 0;
         dropped = 0;
      endfunction

      function void search_graph();
         int unsigned disc [NODES_DEF];
         int unsigned lowl [NODES_DEF];
         bit          cut  [NODES_DEF];
         int unsigned kids [NODES_DEF];
         int unsigned st_node [NODES_DEF];
         int unsigned st_par  [NODES_DEF];
         int unsigned st_cur  [NODES_DEF];
         int unsigned depth, clk, u, v, w, top;
         point_item_type p;
         foreach (disc[i]) begin
            disc[i] = 0; lowl[i] = 0; cut[i] = 0; kids[i] = 0;
         end
         clk = 1;
         disc[0] = 1; lowl[0] = 1;
         st_node[0] = 0; st_par[0] = 0; st_cur[0] = 0;
         depth = 1;
         while (depth > 0) begin
            top = depth - 1;
            u = st_node[top];
            if (st_cur[top] < nbr_list[u].size()) begin
               v = nbr_list[u][st_cur[top]];
               st_cur[top]++;
               if (disc[v] == 0) begin
                  clk++;
                  disc[v] = clk; lowl[v] = clk;
                  st_node[depth] = v; st_par[depth] = u; st_cur[depth] = 0;
                  depth++;
               end else if (v != st_par[top] && disc[v] < lowl[u]) begin
                  lowl[u] = disc[v];
               end
            end else begin
               depth = top;
               if (cut[u] || (disc[u] == 1 && kids[u] > 1)) begin
                  p.node = u[NODE_W-1:0]; p.done = 0; p.ovf = 0;
                  due_points = {due_points, p};
               end
               if (depth > 0) begin
                  w = st_node[depth-1];
                  if (disc[w] > 1 && lowl[u] >= disc[w]) cut[w] = 1;
                  if (lowl[u] < lowl[w]) lowl[w] = lowl[u];
                  if (kids[w] < 2) kids[w]++;
               end
            end
         end
         p.node = '0; p.done = 1; p.ovf = dropped;
         due_points = {due_points, p};
      endfunction

      function void note_edge(int unsigned a, int unsigned b, bit last);
         int unsigned lim;
         lim = (node_count < NODES_DEF) ? node_count : NODES_DEF;
         if (a >= lim || b >= lim || entries + 2 > 2 * EDGES_DEF) begin
            dropped = 1;
         end else begin
            nbr_list[a] = {nbr_list[a], b};
            nbr_list[b] = {nbr_list[b], a};
            entries += 2;
         end
         if (last) begin
            search_graph();
            wipe();
         end
      endfunction

      // returns an empty string when the item matches the oldest expectation
      function string check_point(point_item_type got);
         point_item_type want;
         if (due_points.size() == 0)
            return $sformatf("unexpected item node=%0d end=%0b ovf=%0b",
                             got.node, got.done, got.ovf);
         want = due_points.pop_front();
         if (got.node !== want.node || got.done !== want.done || got.ovf !== want.ovf)
            return $sformatf("item mismatch: got node=%0d end=%0b ovf=%0b, want %0d %0b %0b",
                             got.node, got.done, got.ovf, want.node, want.done, want.ovf);
         return "";
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   apf_req_if req_chan ();
   apf_rsp_if rsp_chan ();

   articulation_point_finder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   cut_vertex_board board;
   int unsigned     mismatches;
   int unsigned     hold_off;     // long receiver stall, counted down by the receiver
   bit              calm;         // no idling on either side while set
   int unsigned     edges_sent;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      mismatches++;
   endtask

   // random gap length: mostly none or short, now and then long
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // input monitor feeds the scoreboard on each accepted item
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_edge(req_chan.end_a, req_chan.end_b, req_chan.last_edge);
   end

   // result monitor
   always @(posedge clock) begin
      point_item_type got;
      string          msg;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.node = rsp_chan.point_node;
         got.done = rsp_chan.end_of_run;
         got.ovf  = rsp_chan.overflow;
         msg = board.check_point(got);
         if (msg != "") report(msg);
      end
   end

   // receiver: random ready, with the odd long hold-off
   initial begin
      int unsigned g;
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_chan.ready = 0;
            hold_off--;
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_chan.ready = 1;
            end else begin
               rsp_chan.ready = 0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   // one edge item; valid stays high between back-to-back items
   task automatic send_edge(input int unsigned a, input int unsigned b, input bit last);
      int unsigned g;
      g = gap_len();
      if (g > 0) begin
         req_chan.valid = 0;
         repeat (g) @(negedge clock);
      end
      req_chan.valid     = 1;
      req_chan.end_a     = a[NODE_W-1:0];
      req_chan.end_b     = b[NODE_W-1:0];
      req_chan.last_edge = last;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // wait for all results, then let the clear finish before touching the register
   task automatic wait_drained();
      req_chan.valid = 0;
      while (board.due_points.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_node_count(input int unsigned nc);
      wait_drained();
      csr_we    = 1;
      csr_wdata = nc[CNT_W-1:0];
      @(negedge clock);
      csr_we    = 0;
      board.node_count = nc;
   endtask

   // random graph: mostly connected-ish over a few low nodes, some noise
   task automatic random_graph(input int unsigned nc, input int unsigned n_edges);
      int unsigned lim, span, a, b, r;
      lim  = (nc < 32) ? nc : 32;
      span = (lim == 0) ? 1 : $urandom_range(1, lim);
      for (int unsigned i = 0; i < n_edges; i++) begin
         r = $urandom_range(0, 99);
         if (lim == 0 || r < 6) begin
            a = $urandom_range(0, 31);
            b = $urandom_range(0, 31);
         end else if (r < 55 && i > 0) begin
            // grow a tree-like shape from node 0 outwards
            a = $urandom_range(0, span - 1);
            b = (a + 1 < span) ? a + 1 : $urandom_range(0, span - 1);
         end else begin
            a = $urandom_range(0, span - 1);
            b = $urandom_range(0, span - 1);
         end
         send_edge(a, b, i == n_edges - 1);
         edges_sent++;
      end
   endtask

   initial begin
      int unsigned phase_nc [11] = '{32, 1, 2, 5, 16, 31, 0, 63, 33, 7, 32};
      int unsigned ph, n;
      board      = new();
      mismatches = 0;
      hold_off   = 0;
      calm       = 0;
      edges_sent = 0;
      reset      = 1;
      csr_we     = 0;
      csr_wdata  = '0;
      req_chan.valid     = 0;
      req_chan.end_a     = '0;
      req_chan.end_b     = '0;
      req_chan.last_edge = 0;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed graphs at the reset node count
      send_edge(0, 1, 0); send_edge(1, 2, 1);                      // path, middle is a cut
      send_edge(0, 1, 0); send_edge(0, 2, 0); send_edge(0, 31, 1);  // star, root is a cut
      send_edge(0, 1, 0); send_edge(0, 1, 0); send_edge(1, 2, 0);   // parallel edge to parent
      send_edge(2, 2, 0); send_edge(31, 30, 0); send_edge(2, 31, 1); // self loop, top ids
      send_edge(0, 0, 1);                                            // lone self loop
      send_edge(1, 2, 1);                                            // root left isolated
      write_node_count(5);
      send_edge(0, 4, 0); send_edge(4, 5, 0); send_edge(31, 3, 1);  // bad ids, last dropped
      write_node_count(0);
      send_edge(0, 0, 1);                                            // everything dropped

      // receiver stalls for a long stretch while edges keep coming
      write_node_count(32);
      calm     = 1;
      hold_off = 400;
      random_graph(32, 40);
      calm = 0;
      // store overflow
      random_graph(32, 135);

      ph = 0;
      while (edges_sent < 340) begin
         write_node_count(phase_nc[ph % 11]);
         repeat (4) begin
            calm = ($urandom_range(0, 5) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            random_graph(phase_nc[ph % 11], n);
         end
         ph++;
      end
      calm = 0;

      wait_drained();
      repeat (50) @(negedge clock);
      if (board.due_points.size() != 0)
         report($sformatf("%0d expected items never arrived", board.due_points.size()));
      if (mismatches == 0)
         $display("articulation_point_finder_top regression: pass");
      else
         $display("articulation_point_finder_top regression: fail");
      $finish;
   end

   initial begin
      #(8 * 1000000);
      $display("articulation_point_finder_top regression: fail");
      $finish;
   end

endmodule
